### rtl/core/ttos_pkg.sv
// Package for the timer table: widths, command and event codes, request types.
// No dependencies.
`default_nettype none
package ttos_pkg;
  localparam int NUM_TIMERS = 16;
  localparam int PERIOD_BITS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int ID_W = $clog2(NUM_TIMERS);

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ARM = 2'd1,
    CMD_CANCEL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_ARM_DONE = 3'd0,
    EV_CANCEL_OK = 3'd1,
    EV_CANCEL_IDLE = 3'd2,
    EV_EXPIRED = 3'd3,
    EV_TICK_NONE = 3'd4
  } event_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] timer_id;
    logic [15:0] period;
    logic periodic;
  } in_req_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [3:0] event_timer;
    logic last;
  } out_req_t;
endpackage
`default_nettype wire

### rtl/core/ttos_if.sv
// Valid/ready channel interfaces for the timer table.
// Depends on ttos_pkg.
`default_nettype none
interface ttos_in_if (input wire logic clk);
  logic valid;
  logic ready;
  ttos_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ttos_out_if (input wire logic clk);
  logic valid;
  logic ready;
  ttos_pkg::out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/ttos_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ttos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] addr,
  input wire logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### rtl/core/timer_table_one_shot_periodic.sv
// Top level of the timer table: sequencer, tick counter and timer slot memory.
// Depends on ttos_pkg, ttos_if and ttos_ram.
//
//   channel  | dir | handshake        | payload
//   in_ch    | in  | valid / ready    | cmd, timer_id, period, periodic
//   out_ch   | out | valid / ready    | event_kind, event_timer, last
//
// Arm and cancel each give one result, registered in out_r.
// A tick scans all slots through the one memory port, once for each fired timer
// and once more unless MAX_RESULTS timers fire.
// Synchronous active-low reset clears the tick count, armed bits and the sequencer.
// The block takes no request while one is in work or a result waits on the output.
`default_nettype none
module timer_table_one_shot_periodic (
  input wire logic clk,
  input wire logic rst_n,
  ttos_in_if.sink in_ch,
  ttos_out_if.source out_ch
);
  localparam int IW = ttos_pkg::ID_W;
  localparam int NT = ttos_pkg::NUM_TIMERS;
  localparam int PB = ttos_pkg::PERIOD_BITS;
  localparam int MW = 32 + PB + 1;
  localparam int CW = $clog2(ttos_pkg::MAX_RESULTS + 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIRE, S_OUT, S_WRITE} state_t;

  state_t state_r, state_nxt;
  logic [31:0] now_r, now_nxt;
  logic [NT-1:0] armed_r, armed_nxt;
  logic [NT-1:0] fired_r, fired_nxt;
  logic [IW:0] idx_r, idx_nxt;
  logic rd_ok_r, rd_ok_nxt;
  logic [IW-1:0] rd_id_r, rd_id_nxt;
  logic found_r, found_nxt;
  logic [31:0] best_key_r, best_key_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  ttos_pkg::out_req_t out_r, out_nxt;

  logic we;
  logic [IW-1:0] addr;
  logic [MW-1:0] wdata, rdata;
  logic [31:0] rd_deadline, diff, key, nd;
  logic [PB-1:0] rd_reload, per_m, rl;
  logic rd_rep;

  ttos_pkg::in_req_t req;
  assign req = in_ch.data;

  ttos_ram #(.WIDTH(MW), .DEPTH(NT)) u_slots (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign rd_deadline = rdata[MW-1 -: 32];
  assign rd_reload = rdata[PB:1];
  assign rd_rep = rdata[0];
  assign diff = rd_deadline - now_r;
  assign key = diff ^ 32'h8000_0000;
  assign per_m = req.period[PB-1:0];
  assign rl = (per_m == '0) ? '0 : per_m - PB'(1);
  assign nd = now_r + 32'(rd_reload);

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_r;

  always_comb begin
    we = 1'b0;
    addr = best_r;
    wdata = {nd, rd_reload, rd_rep};
    if (state_r == S_IDLE) begin
      addr = req.timer_id[IW-1:0];
      wdata = {now_r + 32'(rl), rl, req.periodic};
      we = in_ch.valid && in_ch.ready && (req.cmd == ttos_pkg::CMD_ARM) &&
           (32'(req.timer_id) < 32'(NT));
    end else if (state_r == S_SCAN) begin
      addr = idx_r[IW-1:0];
    end else if (state_r == S_WRITE) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    now_nxt = now_r;
    armed_nxt = armed_r;
    fired_nxt = fired_r;
    idx_nxt = idx_r;
    rd_ok_nxt = 1'b0;
    rd_id_nxt = rd_id_r;
    found_nxt = found_r;
    best_key_nxt = best_key_r;
    best_nxt = best_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          out_nxt.event_timer = req.timer_id;
          out_nxt.last = 1'b1;
          case (req.cmd)
            ttos_pkg::CMD_ARM: begin
              out_nxt.event_kind = ttos_pkg::EV_ARM_DONE;
              out_valid_nxt = 1'b1;
              if (32'(req.timer_id) < 32'(NT)) begin
                armed_nxt[req.timer_id[IW-1:0]] = 1'b1;
              end
            end
            ttos_pkg::CMD_CANCEL: begin
              out_valid_nxt = 1'b1;
              if (32'(req.timer_id) < 32'(NT) && armed_r[req.timer_id[IW-1:0]]) begin
                armed_nxt[req.timer_id[IW-1:0]] = 1'b0;
                out_nxt.event_kind = ttos_pkg::EV_CANCEL_OK;
              end else begin
                out_nxt.event_kind = ttos_pkg::EV_CANCEL_IDLE;
              end
            end
            ttos_pkg::CMD_TICK: begin
              now_nxt = now_r + 32'd1;
              fired_nxt = '0;
              cnt_nxt = '0;
              idx_nxt = '0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (idx_r < (IW+1)'(NT)) begin
          rd_ok_nxt = armed_r[idx_r[IW-1:0]] && !fired_r[idx_r[IW-1:0]];
          rd_id_nxt = idx_r[IW-1:0];
          idx_nxt = idx_r + 1'b1;
        end
        if (rd_ok_r && diff[31] && (!found_r || key < best_key_r)) begin
          found_nxt = 1'b1;
          best_key_nxt = key;
          best_nxt = rd_id_r;
        end
        if (idx_r == (IW+1)'(NT) && !rd_ok_r) begin
          state_nxt = S_FIRE;
        end else if (idx_r == (IW+1)'(NT)) begin
          idx_nxt = idx_r;
          rd_ok_nxt = 1'b0;
        end
      end
      S_FIRE: begin
        if (!out_valid_nxt) begin
          if (!found_r) begin
            if (cnt_r == '0) begin
              out_nxt.event_kind = ttos_pkg::EV_TICK_NONE;
              out_nxt.event_timer = '0;
              out_nxt.last = 1'b1;
              out_valid_nxt = 1'b1;
            end else begin
              out_nxt.last = 1'b1;
              out_valid_nxt = 1'b1;
            end
            state_nxt = S_IDLE;
          end else begin
            if (cnt_r != '0) begin
              out_nxt.last = 1'b0;
              out_valid_nxt = 1'b1;
            end
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_nxt) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        fired_nxt[best_r] = 1'b1;
        if (!rd_rep) begin
          armed_nxt[best_r] = 1'b0;
        end
        out_nxt.event_kind = ttos_pkg::EV_EXPIRED;
        out_nxt.event_timer = 4'(best_r);
        cnt_nxt = cnt_r + 1'b1;
        found_nxt = 1'b0;
        idx_nxt = '0;
        if (cnt_r + 1'b1 == CW'(ttos_pkg::MAX_RESULTS)) begin
          state_nxt = S_FIRE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r <= '0;
      armed_r <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r <= now_nxt;
      armed_r <= armed_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
    fired_r <= fired_nxt;
    idx_r <= idx_nxt;
    rd_id_r <= rd_id_nxt;
    found_r <= found_nxt;
    best_key_r <= best_key_nxt;
    best_r <= best_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result dropped");
  a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (cnt_r < CW'(ttos_pkg::MAX_RESULTS)))
    else $error("too many fired");
  a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(now_r)) else $error("time moved mid tick");
`endif
endmodule
`default_nettype wire

### tb/ttos_event_checker.sv
// Checker for the timer table: watches both channels, predicts the events and compares them.
// Depends on ttos_pkg and ttos_if.
`timescale 1ns / 100ps
module ttos_event_checker (
  input wire logic clk,
  input wire logic rst_n,
  ttos_in_if in_ch,
  ttos_out_if out_ch,
  output int errors,
  output int pending
);
  logic [31:0] now_ticks;
  logic [31:0] due [ttos_pkg::NUM_TIMERS];
  logic [15:0] reload_val [ttos_pkg::NUM_TIMERS];
  logic repeat_on [ttos_pkg::NUM_TIMERS];
  logic armed_on [ttos_pkg::NUM_TIMERS];
  ttos_pkg::out_req_t event_queue[$];

  assign pending = event_queue.size();

  task automatic predict_events(input ttos_pkg::in_req_t req);
    logic fired [ttos_pkg::NUM_TIMERS];
    logic [31:0] diff;
    logic [31:0] key;
    logic [31:0] best_key;
    logic [15:0] rl;
    int best;
    int n;
    ttos_pkg::out_req_t ev;
    case (req.cmd)
      ttos_pkg::CMD_ARM: begin
        rl = (req.period == 16'd0) ? 16'd0 : req.period - 16'd1;
        reload_val[req.timer_id] = rl;
        repeat_on[req.timer_id] = req.periodic;
        due[req.timer_id] = now_ticks + {16'd0, rl};
        armed_on[req.timer_id] = 1'b1;
        ev = '{event_kind: ttos_pkg::EV_ARM_DONE, event_timer: req.timer_id, last: 1'b1};
        event_queue.push_back(ev);
      end
      ttos_pkg::CMD_CANCEL: begin
        if (armed_on[req.timer_id]) begin
          armed_on[req.timer_id] = 1'b0;
          ev = '{event_kind: ttos_pkg::EV_CANCEL_OK, event_timer: req.timer_id, last: 1'b1};
        end else begin
          ev = '{event_kind: ttos_pkg::EV_CANCEL_IDLE, event_timer: req.timer_id,
                 last: 1'b1};
        end
        event_queue.push_back(ev);
      end
      ttos_pkg::CMD_TICK: begin
        for (int i = 0; i < ttos_pkg::NUM_TIMERS; i++) fired[i] = 1'b0;
        now_ticks = now_ticks + 32'd1;
        n = 0;
        while (n < ttos_pkg::MAX_RESULTS) begin
          best = -1;
          best_key = '0;
          for (int i = 0; i < ttos_pkg::NUM_TIMERS; i++) begin
            if (armed_on[i] && !fired[i]) begin
              diff = due[i] - now_ticks;
              if (diff[31]) begin
                key = diff ^ 32'h8000_0000;
                if (best < 0 || key < best_key) begin
                  best = i;
                  best_key = key;
                end
              end
            end
          end
          if (best < 0) break;
          fired[best] = 1'b1;
          if (repeat_on[best]) due[best] = now_ticks + {16'd0, reload_val[best]};
          else armed_on[best] = 1'b0;
          ev = '{event_kind: ttos_pkg::EV_EXPIRED, event_timer: best[3:0], last: 1'b0};
          event_queue.push_back(ev);
          n++;
        end
        if (n == 0) begin
          ev = '{event_kind: ttos_pkg::EV_TICK_NONE, event_timer: 4'd0, last: 1'b1};
          event_queue.push_back(ev);
        end else begin
          event_queue[event_queue.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    ttos_pkg::out_req_t want;
    if (!rst_n) begin
      now_ticks = '0;
      for (int i = 0; i < ttos_pkg::NUM_TIMERS; i++) armed_on[i] = 1'b0;
      event_queue.delete();
      errors <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (event_queue.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected event %p", out_ch.data);
        end else begin
          want = event_queue.pop_front();
          if (want !== out_ch.data) begin
            errors <= errors + 1;
            if (errors < 10) $display("mismatch: expected %p, got %p", want, out_ch.data);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_events(in_ch.data);
    end
  end
endmodule

### tb/tb_timer_table_one_shot_periodic.sv
// Testbench top for the timer table: clock, reset, request stimulus and the verdict.
// Depends on ttos_pkg, ttos_if, ttos_event_checker and the block.
`timescale 1ns / 100ps
module tb_timer_table_one_shot_periodic;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  int errors;
  int pending;
  int idle_cycles;
  int stall_left;
  bit timed_out;

  ttos_in_if in_ch (clk);
  ttos_out_if out_ch (clk);

  timer_table_one_shot_periodic uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  ttos_event_checker checker_i (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .errors(errors), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (rst_n);
    wait (idle_cycles >= WATCHDOG_LIMIT);
    timed_out = 1'b1;
    $display("FAIL");
    $finish;
  end

  task automatic send_request(input logic [1:0] cmd, input logic [3:0] id,
                              input logic [15:0] per, input logic rep);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{cmd: cmd, timer_id: id, period: per, periodic: rep};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  task automatic random_request();
    int r;
    logic [3:0] id;
    logic [15:0] per;
    r = $urandom_range(0, 99);
    id = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0: per = 16'($urandom_range(0, 3));
      1: per = 16'($urandom_range(0, 12));
      2: per = 16'($urandom);
      default: per = 16'($urandom_range(1, 6));
    endcase
    if (r < 45) send_request(ttos_pkg::CMD_TICK, 4'($urandom), 16'($urandom), 1'($urandom));
    else if (r < 80) send_request(ttos_pkg::CMD_ARM, id, per, 1'($urandom));
    else if (r < 95) send_request(ttos_pkg::CMD_CANCEL, id, 16'($urandom), 1'($urandom));
    else send_request(CMD_UNUSED, 4'($urandom), 16'($urandom), 1'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    timed_out = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_request(ttos_pkg::CMD_TICK, 4'd0, 16'd0, 1'b0);
    send_request(ttos_pkg::CMD_CANCEL, 4'd15, 16'hFFFF, 1'b1);
    send_request(ttos_pkg::CMD_ARM, 4'd0, 16'd0, 1'b0);
    send_request(ttos_pkg::CMD_ARM, 4'd15, 16'd1, 1'b1);
    send_request(ttos_pkg::CMD_ARM, 4'd3, 16'hFFFF, 1'b1);
    send_request(ttos_pkg::CMD_TICK, 4'd15, 16'hFFFF, 1'b1);
    send_request(ttos_pkg::CMD_TICK, 4'd0, 16'd0, 1'b0);
    send_request(ttos_pkg::CMD_ARM, 4'd7, 16'd2, 1'b0);
    send_request(ttos_pkg::CMD_ARM, 4'd7, 16'd3, 1'b0);
    send_request(ttos_pkg::CMD_CANCEL, 4'd3, 16'd0, 1'b0);
    send_request(CMD_UNUSED, 4'd15, 16'hFFFF, 1'b1);
    for (int i = 0; i < ttos_pkg::NUM_TIMERS; i++) begin
      send_request(ttos_pkg::CMD_ARM, 4'(i), 16'd0, 1'(i % 2));
    end
    send_request(ttos_pkg::CMD_TICK, 4'd0, 16'd0, 1'b0);
    send_request(ttos_pkg::CMD_TICK, 4'd0, 16'd0, 1'b0);
    drain();
    for (int i = 0; i < 70; i++) random_request();
    drain();
    repeat (60) @(posedge clk);
    if (!timed_out) begin
      if (errors == 0 && pending == 0) $display("PASS");
      else $display("FAIL");
      $finish;
    end
  end
endmodule
